### sv/plt_pkg.sv
`default_nettype none
package plt_pkg;

  localparam int MAX_RES = 4;
  localparam int Q_DEPTH = 4;

  // token kinds
  localparam logic [5:0] K_EOF           = 6'd0;
  localparam logic [5:0] K_NEWLINE       = 6'd1;
  localparam logic [5:0] K_ARROW         = 6'd2;
  localparam logic [5:0] K_SERIES        = 6'd3;
  localparam logic [5:0] K_MINUS         = 6'd4;
  localparam logic [5:0] K_MANY_TO_ONE   = 6'd5;
  localparam logic [5:0] K_GREATER       = 6'd6;
  localparam logic [5:0] K_ONE_TO_MANY   = 6'd7;
  localparam logic [5:0] K_LESS          = 6'd8;
  localparam logic [5:0] K_PARALLEL      = 6'd9;
  localparam logic [5:0] K_INVALID       = 6'd10;
  localparam logic [5:0] K_CROSS         = 6'd11;
  localparam logic [5:0] K_ELIPSIS       = 6'd12;
  localparam logic [5:0] K_DOT           = 6'd13;
  localparam logic [5:0] K_OPEN_BRACE    = 6'd14;
  localparam logic [5:0] K_CLOSE_BRACE   = 6'd15;
  localparam logic [5:0] K_OPEN_PAREN    = 6'd16;
  localparam logic [5:0] K_CLOSE_PAREN   = 6'd17;
  localparam logic [5:0] K_OPEN_BRACKET  = 6'd18;
  localparam logic [5:0] K_CLOSE_BRACKET = 6'd19;
  localparam logic [5:0] K_COLON         = 6'd20;
  localparam logic [5:0] K_COMMA         = 6'd21;
  localparam logic [5:0] K_AMPERSAND     = 6'd22;
  localparam logic [5:0] K_PERCENT       = 6'd23;
  localparam logic [5:0] K_BACKTICK      = 6'd24;
  localparam logic [5:0] K_ASTERISK      = 6'd25;
  localparam logic [5:0] K_PLUS          = 6'd26;
  localparam logic [5:0] K_SLASH         = 6'd27;
  localparam logic [5:0] K_CARET         = 6'd28;
  localparam logic [5:0] K_VERT_BAR      = 6'd29;
  localparam logic [5:0] K_NUMBER        = 6'd30;
  localparam logic [5:0] K_OBJECT        = 6'd31;
  localparam logic [5:0] K_IDENT         = 6'd32;
  localparam logic [5:0] K_STRING        = 6'd33;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  // result kinds
  localparam logic RK_CHAR  = 1'b0;
  localparam logic RK_TOKEN = 1'b1;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  typedef enum logic [3:0] {
    M_START   = 4'd0,
    M_WS      = 4'd1,
    M_OPER    = 4'd2,
    M_NUM1    = 4'd3,
    M_NUM     = 4'd4,
    M_NUMSP   = 4'd5,
    M_IDENT   = 4'd6,
    M_COMMENT = 4'd7,
    M_BSLASH  = 4'd8,
    M_STR     = 4'd9,
    M_ESC     = 4'd10
  } mode_t;

  typedef struct packed {
    logic       rk;
    logic [5:0] kind;
    logic [7:0] vc;
    logic [15:0] line;
    logic [1:0] err;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         last_idx;
  } bundle_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
  endfunction

  // kind of a one-character token; K_INVALID when the byte is not one
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      8'h7B:   k = K_OPEN_BRACE;
      8'h7D:   k = K_CLOSE_BRACE;
      8'h28:   k = K_OPEN_PAREN;
      8'h29:   k = K_CLOSE_PAREN;
      8'h5B:   k = K_OPEN_BRACKET;
      8'h5D:   k = K_CLOSE_BRACKET;
      8'h3A:   k = K_COLON;
      8'h2C:   k = K_COMMA;
      8'h26:   k = K_AMPERSAND;
      8'h25:   k = K_PERCENT;
      8'h60:   k = K_BACKTICK;
      8'h2A:   k = K_ASTERISK;
      8'h2B:   k = K_PLUS;
      8'h2F:   k = K_SLASH;
      8'h5E:   k = K_CARET;
      8'h7C:   k = K_VERT_BAR;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

  // held operator not followed by its partner
  function automatic logic [5:0] lone_kind(input logic [7:0] h);
    logic [5:0] k;
    unique case (h)
      CH_GT:    k = K_GREATER;
      CH_LT:    k = K_LESS;
      CH_DOT:   k = K_DOT;
      CH_MINUS: k = K_MINUS;
      default:  k = K_INVALID;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### sv/plt_front.sv
`default_nettype none
module plt_front #(
  parameter int LINE_COUNT_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       source_byte,
  input  wire logic             end_of_input,
  input  wire logic             q_ready,
  output logic                  push_valid,
  output plt_pkg::bundle_t      push_data
);
  import plt_pkg::*;

  mode_t                      mode, mode_next;
  logic [7:0]                 held_char, held_char_next;
  logic [1:0]                 held_count, held_count_next;
  logic [LINE_COUNT_BITS-1:0] line_count, line_count_next;

  logic                       accept;
  logic [2:0]                 n;
  res_t [MAX_RES-1:0]         res;
  logic                       relex;
  logic                       str;
  logic [7:0]                 c;

  function automatic logic [15:0] sat16(input logic [LINE_COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (|w[31:16]) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic res_t mk_tok(input logic [5:0] k, input logic [15:0] l,
                                  input logic [1:0] e);
    res_t r;
    r.rk   = RK_TOKEN;
    r.kind = k;
    r.vc   = 8'h00;
    r.line = l;
    r.err  = (k == K_INVALID) ? ERR_INVALID : e;
    return r;
  endfunction

  function automatic res_t mk_chr(input logic [5:0] k, input logic [7:0] v,
                                  input logic [15:0] l);
    res_t r;
    r.rk   = RK_CHAR;
    r.kind = k;
    r.vc   = v;
    r.line = l;
    r.err  = ERR_NONE;
    return r;
  endfunction

  assign c        = source_byte;
  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_START;
      held_char  <= 8'h00;
      held_count <= 2'd0;
      line_count <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      held_char  <= held_char_next;
      held_count <= held_count_next;
      line_count <= line_count_next;
    end
  end

  always_comb begin
    mode_next       = mode;
    held_char_next  = held_char;
    held_count_next = held_count;
    line_count_next = line_count;
    res             = '0;
    n               = 3'd0;
    relex           = 1'b0;
    str             = 1'b0;

    if (end_of_input) begin
      unique case (mode)
        M_OPER: begin
          if (held_char == CH_LOW_X) begin
            res[n[1:0]] = mk_chr(K_IDENT, CH_LOW_X, sat16(line_count_next)); n = n + 3'd1;
            res[n[1:0]] = mk_tok(K_IDENT, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
          end else begin
            res[n[1:0]] = mk_tok(lone_kind(held_char), sat16(line_count_next), ERR_NONE);
            n = n + 3'd1;
            if (held_char == CH_MINUS && held_count >= 2'd2) begin
              res[n[1:0]] = mk_tok(K_MINUS, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
            end
          end
        end
        M_NUM1, M_NUM, M_NUMSP: begin
          res[n[1:0]] = mk_tok(K_NUMBER, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
        end
        M_IDENT: begin
          res[n[1:0]] = mk_tok(K_IDENT, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
        end
        M_STR, M_ESC: begin
          res[n[1:0]] = mk_tok(K_STRING, sat16(line_count_next), ERR_UNTERM); n = n + 3'd1;
        end
        default: ;
      endcase
      res[n[1:0]] = mk_tok(K_EOF, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
      mode_next       = M_START;
      held_char_next  = 8'h00;
      held_count_next = 2'd0;
      line_count_next = '0;
    end else begin
      unique case (mode)
        M_OPER: begin
          if (held_char == CH_MINUS) begin
            if (held_count >= 2'd2 && c == CH_GT) begin
              res[n[1:0]] = mk_tok(K_SERIES, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
              mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
            end else if (held_count < 2'd2 && c == CH_GT) begin
              res[n[1:0]] = mk_tok(K_ARROW, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
              mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
            end else begin
              // a pending double minus releases one minus first
              if (held_count >= 2'd2) begin
                res[n[1:0]] = mk_tok(K_MINUS, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
              end
              if (c == CH_MINUS) begin
                held_count_next = 2'd2;
              end else begin
                res[n[1:0]] = mk_tok(K_MINUS, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
                mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
                relex = 1'b1;
              end
            end
          end else if (held_char == CH_LOW_X) begin
            if (c == CH_GT) begin
              res[n[1:0]] = mk_tok(K_CROSS, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
              mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
            end else begin
              // the x opens an identifier
              res[n[1:0]] = mk_chr(K_IDENT, CH_LOW_X, sat16(line_count_next)); n = n + 3'd1;
              held_char_next  = 8'h00;
              held_count_next = 2'd0;
              if (is_alpha(c) || is_dig(c)) begin
                res[n[1:0]] = mk_chr(K_IDENT, c, sat16(line_count_next)); n = n + 3'd1;
                mode_next = M_IDENT;
              end else if (c == CH_TILDE) begin
                res[n[1:0]] = mk_tok(K_OBJECT, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
                mode_next = M_START;
              end else begin
                res[n[1:0]] = mk_tok(K_IDENT, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
                mode_next = M_START;
                relex     = 1'b1;
              end
            end
          end else if (held_char == CH_DOT && c == CH_DOT) begin
            res[n[1:0]] = mk_tok(K_ELIPSIS, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
            mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
          end else if (c == CH_GT && held_char == CH_GT) begin
            res[n[1:0]] = mk_tok(K_MANY_TO_ONE, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
            mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
          end else if (c == CH_GT && held_char == CH_LT) begin
            res[n[1:0]] = mk_tok(K_ONE_TO_MANY, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
            mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
          end else if (c == CH_GT && held_char == CH_EQ) begin
            res[n[1:0]] = mk_tok(K_PARALLEL, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
            mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
          end else begin
            res[n[1:0]] = mk_tok(lone_kind(held_char), sat16(line_count_next), ERR_NONE);
            n = n + 3'd1;
            mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
            relex = 1'b1;
          end
        end
        M_NUM1, M_NUMSP: begin
          if (is_dig(c)) begin
            res[n[1:0]] = mk_chr(K_NUMBER, c, sat16(line_count_next)); n = n + 3'd1;
            mode_next = M_NUM;
          end else begin
            res[n[1:0]] = mk_tok(K_NUMBER, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
            mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
            relex = 1'b1;
          end
        end
        M_NUM: begin
          if (is_dig(c)) begin
            res[n[1:0]] = mk_chr(K_NUMBER, c, sat16(line_count_next)); n = n + 3'd1;
          end else if (c == CH_SPACE) begin
            mode_next = M_NUMSP;
          end else begin
            res[n[1:0]] = mk_tok(K_NUMBER, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
            mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
            relex = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_dig(c)) begin
            res[n[1:0]] = mk_chr(K_IDENT, c, sat16(line_count_next)); n = n + 3'd1;
          end else if (c == CH_TILDE) begin
            res[n[1:0]] = mk_tok(K_OBJECT, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
            mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
          end else begin
            res[n[1:0]] = mk_tok(K_IDENT, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
            mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
            relex = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_LF) begin
            if (line_count_next != {LINE_COUNT_BITS{1'b1}})
              line_count_next = line_count_next + 1'b1;
            res[n[1:0]] = mk_tok(K_NEWLINE, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
            mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
          end
        end
        M_BSLASH: begin
          // continuation: the escaped byte is dropped, a newline still counts
          if (c == CH_LF && line_count_next != {LINE_COUNT_BITS{1'b1}})
            line_count_next = line_count_next + 1'b1;
          mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
        end
        M_STR: begin
          str = 1'b1;
        end
        M_ESC: begin
          mode_next = M_STR;
          if (c == CH_LOW_N) begin
            res[n[1:0]] = mk_chr(K_STRING, CH_LF, sat16(line_count_next)); n = n + 3'd1;
          end else begin
            str = 1'b1;
          end
        end
        default: begin
          relex = 1'b1;
        end
      endcase

      if (str) begin
        if (c == CH_QUOTE) begin
          res[n[1:0]] = mk_tok(K_STRING, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
          mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
        end else if (c == CH_BSLASH) begin
          mode_next = M_ESC;
        end else begin
          res[n[1:0]] = mk_chr(K_STRING, c, sat16(line_count_next)); n = n + 3'd1;
        end
      end

      // start of a token; carriage return only skipped straight after a token
      if (relex) begin
        if (c == CH_CR && mode_next == M_START) begin
          mode_next = M_WS;
        end else if (c == CH_SPACE || c == CH_TAB) begin
          mode_next = M_WS;
        end else begin
          mode_next = M_START; held_char_next = 8'h00; held_count_next = 2'd0;
          if (c == CH_SEMI) begin
            mode_next = M_COMMENT;
          end else if (c == CH_LF) begin
            if (line_count_next != {LINE_COUNT_BITS{1'b1}})
              line_count_next = line_count_next + 1'b1;
            res[n[1:0]] = mk_tok(K_NEWLINE, sat16(line_count_next), ERR_NONE); n = n + 3'd1;
          end else if (c == CH_MINUS || c == CH_GT || c == CH_LT || c == CH_EQ ||
                       c == CH_DOT || c == CH_LOW_X) begin
            mode_next = M_OPER; held_char_next = c; held_count_next = 2'd1;
          end else if (single_kind(c) != K_INVALID) begin
            res[n[1:0]] = mk_tok(single_kind(c), sat16(line_count_next), ERR_NONE);
            n = n + 3'd1;
          end else if (c == CH_BSLASH) begin
            mode_next = M_BSLASH;
          end else if (is_dig(c)) begin
            res[n[1:0]] = mk_chr(K_NUMBER, c, sat16(line_count_next)); n = n + 3'd1;
            mode_next = M_NUM1;
          end else if (is_alpha(c)) begin
            res[n[1:0]] = mk_chr(K_IDENT, c, sat16(line_count_next)); n = n + 3'd1;
            mode_next = M_IDENT;
          end else if (c == CH_QUOTE) begin
            mode_next = M_STR;
          end else begin
            res[n[1:0]] = mk_tok(K_INVALID, sat16(line_count_next), ERR_INVALID);
            n = n + 3'd1;
          end
        end
      end
    end
  end

  assign push_valid         = accept && (n != 3'd0);
  assign push_data.res      = res;
  assign push_data.last_idx = 2'(n - 3'd1);

endmodule
`default_nettype wire

### sv/plt_queue.sv
`default_nettype none
module plt_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  input  wire plt_pkg::bundle_t push_data,
  output logic                  q_ready,
  output logic                  q_valid,
  output plt_pkg::bundle_t      head,
  input  wire logic             pop
);
  import plt_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  bundle_t       store [Q_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   fill;
  logic          do_push, do_pop;

  assign q_ready = (fill != (PW+1)'(Q_DEPTH));
  assign q_valid = (fill != '0);
  assign head    = store[rd_ptr];
  assign do_push = push_valid && q_ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

### sv/plt_back.sv
`default_nettype none
module plt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire plt_pkg::bundle_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output plt_pkg::res_t         out_res,
  output logic                  out_last
);
  import plt_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = q_valid && (!out_valid || out_ready);
  assign at_end = (idx == head.last_idx);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= at_end ? 2'd0 : idx + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= head.res[idx];
      out_last <= at_end;
    end
  end

endmodule
`default_nettype wire

### sv/patch_language_tokenizer.sv
// Streaming tokenizer for a small patching language.
// Input channel (in_valid/in_ready): one source byte per transaction, or an
// end_of_input marker that flushes the pending token and gives an eof token.
// Output channel (out_valid/out_ready): one result per transaction, either a
// value character of the token being built or a completed token, with the
// line count and an error code; last_of_run marks the final result of the
// input transaction that caused it. A byte can give 0 to 3 results.
// Front: lexing mode, held operator character and line counter, all results
// of a byte worked out in the cycle it is accepted.
// Queue: 4 bundles of results, one bundle per input byte that gives results.
// Back: unpacks a bundle one result per cycle, while out_ready is high, into
// the output register.
// Throughput, with out_ready high: one byte per cycle while each byte gives
// at most one result; otherwise the output side sets the rate at one result
// per cycle, the single output register being the limit.
// Receiver stall: the output register holds; the queue fills, and in_ready
// drops once all 4 bundles are taken. Bytes that give no result never wait
// on the output side unless the queue is full.
// Reset: mode back to start of token, line count 0, queue and output empty.
// After end_of_input the mode and line count return to the same values.
`default_nettype none
module patch_language_tokenizer #(
  parameter int LINE_COUNT_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] source_byte,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            result_kind,
  output logic [5:0]      token_kind,
  output logic [7:0]      value_char,
  output logic [15:0]     line_number,
  output logic [1:0]      error_code,
  output logic            last_of_run
);
  import plt_pkg::*;

  logic    q_ready;
  logic    push_valid;
  bundle_t push_data;
  logic    q_valid;
  bundle_t head;
  logic    pop;
  res_t    out_res;

  // front: lexer and its state
  plt_front #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .source_byte (source_byte),
    .end_of_input(end_of_input),
    .q_ready     (q_ready),
    .push_valid  (push_valid),
    .push_data   (push_data)
  );

  // queue between the lexer and the output side
  plt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_data (push_data),
    .q_ready   (q_ready),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop)
  );

  // back: one result per transaction
  plt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res),
    .out_last (last_of_run)
  );

  assign result_kind = out_res.rk;
  assign token_kind  = out_res.kind;
  assign value_char  = out_res.vc;
  assign line_number = out_res.line;
  assign error_code  = out_res.err;

endmodule
`default_nettype wire

### sv/plt_checker.sv
`default_nettype none
module plt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] source_byte,
  input wire logic       end_of_input,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       result_kind,
  input wire logic [5:0] token_kind,
  input wire logic [7:0] value_char,
  input wire logic [15:0] line_number,
  input wire logic [1:0] error_code,
  input wire logic       last_of_run
);
  import plt_pkg::*;

  // an offered byte waits unchanged until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(source_byte) && $stable(end_of_input))
    else $error("input changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
      $stable(value_char) && $stable(line_number) && $stable(last_of_run))
    else $error("result changed while stalled");

  // eof always closes the run of its input transaction
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RK_TOKEN && token_kind == K_EOF |-> last_of_run)
    else $error("eof token not last of run");

  // value characters only belong to numbers, identifiers and strings
  a_char_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RK_CHAR |->
      error_code == ERR_NONE &&
      (token_kind == K_NUMBER || token_kind == K_IDENT || token_kind == K_STRING))
    else $error("bad value character result");

  // error codes tie to their token kinds
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |->
      result_kind == RK_TOKEN &&
      ((error_code == ERR_INVALID && token_kind == K_INVALID) ||
       (error_code == ERR_UNTERM && token_kind == K_STRING)))
    else $error("error code does not match token");

endmodule

bind patch_language_tokenizer plt_checker u_plt_checker (.*);
`default_nettype wire

### tb/patch_language_tokenizer_tb.sv
`default_nettype none
module patch_language_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plt_pkg::*;

  // ---------------------------------------------------------------------------
  // Run shape
  // ---------------------------------------------------------------------------
  localparam int          RANDOM_ITEMS  = 125;
  localparam int          MAX_WAIT      = 12;     // per-transaction idle draw
  localparam int          HOLD_AT       = 30;     // results seen before long hold
  localparam int          HOLD_LEN      = 200;    // long receiver hold, cycles
  localparam int          IDLE_LIMIT    = 3000;   // watchdog: cycles with no transaction
  localparam int          DRAIN_CYCLES  = 10;     // slack after the last due result
  localparam logic [15:0] LINE_MAX      = 16'hFFFF;

  // one-character tokens, kind = K_FIRST_PUNCT + index; index 0 in the low byte
  localparam logic [5:0]   K_FIRST_PUNCT = 6'd14;
  localparam logic [127:0] PUNCT_CHARS   = {
    8'h7C, 8'h5E, 8'h2F, 8'h2B, 8'h2A, 8'h60, 8'h25, 8'h26,
    8'h2C, 8'h3A, 8'h5D, 8'h5B, 8'h29, 8'h28, 8'h7D, 8'h7B
  };

  typedef struct {
    logic        rk;
    logic [5:0]  kind;
    logic [7:0]  vc;
    logic [15:0] line;
    logic [1:0]  err;
    logic        last;
  } lex_result_t;

  typedef struct {
    logic [7:0]  ch;
    logic        eoi;
    int unsigned gap;
    bit          drain;   // hold this transaction back until every result is in
  } text_item_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  source_byte  = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        result_kind;
  logic [5:0]  token_kind;
  logic [7:0]  value_char;
  logic [15:0] line_number;
  logic [1:0]  error_code;
  logic        last_of_run;

  initial begin
    forever #6 clk = ~clk;
  end

  patch_language_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .source_byte  (source_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .token_kind   (token_kind),
    .value_char   (value_char),
    .line_number  (line_number),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

  // ---------------------------------------------------------------------------
  // Lexer model: own copy of mode, held operator and line count
  // ---------------------------------------------------------------------------
  mode_t       lx_mode   = M_START;
  logic [7:0]  lx_held   = 8'h00;
  logic [1:0]  lx_held_n = 2'd0;
  logic [15:0] lx_line   = 16'd0;

  lex_result_t step_results[$];   // results of the byte being modelled
  lex_result_t tokens_due[$];     // expected results, oldest first
  text_item_t  text_queue[$];     // transactions still to be offered

  int unsigned n_errors     = 0;
  int unsigned results_seen = 0;

  function void add_result(logic rk, logic [5:0] kind, logic [7:0] vc, logic [1:0] err);
    lex_result_t r;
    if (step_results.size() < MAX_RES) begin
      r.rk   = rk;
      r.kind = kind;
      r.vc   = vc;
      r.line = lx_line;
      r.err  = err;
      r.last = 1'b0;
      step_results.insert(step_results.size(), r);
    end
  endfunction

  function void add_token(logic [5:0] kind);
    add_result(RK_TOKEN, kind, 8'h00, (kind == K_INVALID) ? ERR_INVALID : ERR_NONE);
  endfunction

  function void add_char(logic [5:0] kind, logic [7:0] c);
    add_result(RK_CHAR, kind, c, ERR_NONE);
  endfunction

  function void count_line();
    if (lx_line != LINE_MAX) lx_line = lx_line + 16'd1;
  endfunction

  function void back_to_start();
    lx_mode   = M_START;
    lx_held   = 8'h00;
    lx_held_n = 2'd0;
  endfunction

  function bit is_numeral(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function bit is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function logic [5:0] punct_kind(logic [7:0] c);
    for (int i = 0; i < 16; i++)
      if (PUNCT_CHARS[8*i +: 8] == c) return K_FIRST_PUNCT + 6'(i);
    return K_INVALID;
  endfunction

  // an operator start left on its own
  function logic [5:0] unpaired_kind(logic [7:0] h);
    if (h == CH_GT)    return K_GREATER;
    if (h == CH_LT)    return K_LESS;
    if (h == CH_DOT)   return K_DOT;
    if (h == CH_MINUS) return K_MINUS;
    return K_INVALID;
  endfunction

  // one source byte; a byte that closes a token without belonging to it
  // goes round the loop again from the start of a token
  function void tokenise_byte(logic [7:0] c);
    bit         again;
    logic [7:0] h;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lx_mode)
        M_OPER: begin
          h = lx_held;
          if (h == CH_MINUS) begin
            if (lx_held_n >= 2) begin
              if (c == CH_GT) begin
                add_token(K_SERIES);
                back_to_start();
              end else begin
                // "--x": first minus goes out, second is still held
                add_token(K_MINUS);
                lx_held_n = 2'd1;
                again     = 1'b1;
              end
            end else if (c == CH_GT) begin
              add_token(K_ARROW);
              back_to_start();
            end else if (c == CH_MINUS) begin
              lx_held_n = 2'd2;
            end else begin
              add_token(K_MINUS);
              back_to_start();
              again = 1'b1;
            end
          end else if (h == CH_LOW_X) begin
            if (c == CH_GT) begin
              add_token(K_CROSS);
              back_to_start();
            end else begin
              // not a cross connection, so x opens an identifier
              add_char(K_IDENT, CH_LOW_X);
              back_to_start();
              lx_mode = M_IDENT;
              again   = 1'b1;
            end
          end else if (h == CH_DOT && c == CH_DOT) begin
            add_token(K_ELIPSIS);
            back_to_start();
          end else if (c == CH_GT && h == CH_GT) begin
            add_token(K_MANY_TO_ONE);
            back_to_start();
          end else if (c == CH_GT && h == CH_LT) begin
            add_token(K_ONE_TO_MANY);
            back_to_start();
          end else if (c == CH_GT && h == CH_EQ) begin
            add_token(K_PARALLEL);
            back_to_start();
          end else begin
            add_token(unpaired_kind(h));
            back_to_start();
            again = 1'b1;
          end
        end
        M_NUM1: begin
          if (is_numeral(c)) begin
            add_char(K_NUMBER, c);
            lx_mode = M_NUM;
          end else begin
            add_token(K_NUMBER);
            back_to_start();
            again = 1'b1;
          end
        end
        M_NUM: begin
          if (is_numeral(c)) begin
            add_char(K_NUMBER, c);
          end else if (c == CH_SPACE) begin
            lx_mode = M_NUMSP;
          end else begin
            add_token(K_NUMBER);
            back_to_start();
            again = 1'b1;
          end
        end
        M_NUMSP: begin
          if (is_numeral(c)) begin
            add_char(K_NUMBER, c);
            lx_mode = M_NUM;
          end else begin
            add_token(K_NUMBER);
            back_to_start();
            again = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_letter(c) || is_numeral(c)) begin
            add_char(K_IDENT, c);
          end else if (c == CH_TILDE) begin
            add_token(K_OBJECT);
            back_to_start();
          end else begin
            add_token(K_IDENT);
            back_to_start();
            again = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_LF) begin
            count_line();
            add_token(K_NEWLINE);
            back_to_start();
          end
        end
        M_BSLASH: begin
          // continuation: byte dropped, a newline still counts
          if (c == CH_LF) count_line();
          back_to_start();
        end
        M_STR: begin
          if (c == CH_QUOTE) begin
            add_token(K_STRING);
            back_to_start();
          end else if (c == CH_BSLASH) begin
            lx_mode = M_ESC;
          end else begin
            add_char(K_STRING, c);
          end
        end
        M_ESC: begin
          lx_mode = M_STR;
          if (c == CH_LOW_N) add_char(K_STRING, CH_LF);
          else again = 1'b1;     // backslash dropped, byte taken as is
        end
        default: begin
          if (c == CH_CR && lx_mode == M_START) begin
            lx_mode = M_WS;      // carriage return only skipped first
          end else if (c == CH_SPACE || c == CH_TAB) begin
            lx_mode = M_WS;
          end else begin
            back_to_start();
            if (c == CH_SEMI) begin
              lx_mode = M_COMMENT;
            end else if (c == CH_LF) begin
              count_line();
              add_token(K_NEWLINE);
            end else if (c == CH_MINUS || c == CH_GT || c == CH_LT || c == CH_EQ ||
                         c == CH_DOT || c == CH_LOW_X) begin
              lx_mode   = M_OPER;
              lx_held   = c;
              lx_held_n = 2'd1;
            end else if (punct_kind(c) != K_INVALID) begin
              add_token(punct_kind(c));
            end else if (c == CH_BSLASH) begin
              lx_mode = M_BSLASH;
            end else if (is_numeral(c)) begin
              add_char(K_NUMBER, c);
              lx_mode = M_NUM1;
            end else if (is_letter(c)) begin
              add_char(K_IDENT, c);
              lx_mode = M_IDENT;
            end else if (c == CH_QUOTE) begin
              lx_mode = M_STR;
            end else begin
              add_token(K_INVALID);
            end
          end
        end
      endcase
    end
  endfunction

  // end of text: flush whatever is open, then eof, then back to reset state
  function void close_text();
    case (lx_mode)
      M_OPER: begin
        if (lx_held == CH_LOW_X) begin
          add_char(K_IDENT, CH_LOW_X);
          add_token(K_IDENT);
        end else begin
          add_token(unpaired_kind(lx_held));
          if (lx_held == CH_MINUS && lx_held_n >= 2) add_token(K_MINUS);
        end
      end
      M_NUM1, M_NUM, M_NUMSP: add_token(K_NUMBER);
      M_IDENT:                add_token(K_IDENT);
      M_STR, M_ESC:           add_result(RK_TOKEN, K_STRING, 8'h00, ERR_UNTERM);
      default: ;
    endcase
    add_token(K_EOF);
    back_to_start();
    lx_line = 16'd0;
  endfunction

  function void predict_item(logic [7:0] c, logic eoi);
    step_results.delete();
    if (eoi) close_text();
    else tokenise_byte(c);
    if (step_results.size() != 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[i]) tokens_due.insert(tokens_due.size(), step_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  bit quiet      = 1'b0;   // no idling on the input side
  bit drain_next = 1'b0;

  function void push_byte(logic [7:0] c, logic eoi);
    text_item_t it;
    it.ch    = c;
    it.eoi   = eoi;
    it.gap   = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    it.drain = drain_next;
    drain_next = 1'b0;
    text_queue.insert(text_queue.size(), it);
  endfunction

  function void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endfunction

  // byte is ignored on an end-of-input transaction, so randomise it
  function void push_end();
    push_byte(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function string op_word(int unsigned i);
    case (i)
      0:  return "->";
      1:  return "-->";
      2:  return "--";
      3:  return "---";
      4:  return ">>";
      5:  return "<>";
      6:  return "=>";
      7:  return "x>";
      8:  return "..";
      9:  return ".";
      10: return "-";
      11: return ">";
      12: return "<";
      13: return "=";
      14: return "x";
      default: return "=x";
    endcase
  endfunction

  function logic [7:0] rand_letter();
    case ($urandom_range(0, 4))
      0, 1:    return 8'h61 + 8'($urandom_range(0, 25));   // a..z
      2, 3:    return 8'h41 + 8'($urandom_range(0, 25));   // A..Z
      default: return 8'h5F;                                // underscore
    endcase
  endfunction

  function logic [7:0] rand_printable();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // one well-formed piece of text, or noise
  function void add_fragment();
    int unsigned n;
    case ($urandom_range(0, 12))
      0, 1: push_text(op_word($urandom_range(0, 15)));
      2: push_byte(PUNCT_CHARS[8*$urandom_range(0, 15) +: 8], 1'b0);
      3: begin
        case ($urandom_range(0, 3))
          0: push_byte(CH_SPACE, 1'b0);
          1: push_byte(CH_TAB, 1'b0);
          2: push_byte(CH_CR, 1'b0);
          default: begin
            push_byte(CH_SPACE, 1'b0);
            push_byte(CH_CR, 1'b0);
          end
        endcase
      end
      4: begin
        // digit run, single (sometimes double) spaces between digits
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          push_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
          if (i != n - 1 && $urandom_range(0, 2) == 0) push_byte(CH_SPACE, 1'b0);
          if (i != n - 1 && $urandom_range(0, 7) == 0) push_byte(CH_SPACE, 1'b0);
        end
      end
      5: begin
        push_byte(rand_letter(), 1'b0);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 2) == 0) push_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
          else push_byte(rand_letter(), 1'b0);
        end
        if ($urandom_range(0, 1) == 0) push_byte(CH_TILDE, 1'b0);
      end
      6: begin
        push_byte(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 5))
            0: push_text("\\n");
            1: begin
              push_byte(CH_BSLASH, 1'b0);
              push_byte(rand_printable(), 1'b0);
            end
            2:       push_byte(CH_LF, 1'b0);
            default: push_byte(rand_printable(), 1'b0);
          endcase
        end
        // now and then the text ends inside the string
        if ($urandom_range(0, 3) != 0) push_byte(CH_QUOTE, 1'b0);
        else push_end();
      end
      7: begin
        push_byte(CH_SEMI, 1'b0);
        repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 3) != 0) push_byte(CH_LF, 1'b0);
      end
      8: begin
        push_byte(CH_BSLASH, 1'b0);
        if ($urandom_range(0, 1) == 0) push_byte(CH_LF, 1'b0);
        else push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      9:  push_byte(CH_LF, 1'b0);
      10: push_byte(8'($urandom_range(0, 255)), 1'b0);
      11: if ($urandom_range(0, 2) == 0) push_end();
      default: push_byte(rand_printable(), 1'b0);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting: one line each, all counted
  // ---------------------------------------------------------------------------
  task note_mismatch(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  task compare_token();
    lex_result_t want;
    if (tokens_due.size() == 0) begin
      note_mismatch($sformatf("result with nothing due: kind %0d token %0d char %02h",
                              result_kind, token_kind, value_char));
    end else begin
      want = tokens_due.pop_front();
      if (result_kind !== want.rk)
        note_mismatch($sformatf("result_kind %0d, want %0d", result_kind, want.rk));
      if (token_kind !== want.kind)
        note_mismatch($sformatf("token_kind %0d, want %0d", token_kind, want.kind));
      if (value_char !== want.vc)
        note_mismatch($sformatf("value_char %02h, want %02h", value_char, want.vc));
      if (line_number !== want.line)
        note_mismatch($sformatf("line_number %0d, want %0d", line_number, want.line));
      if (error_code !== want.err)
        note_mismatch($sformatf("error_code %0d, want %0d", error_code, want.err));
      if (last_of_run !== want.last)
        note_mismatch($sformatf("last_of_run %0d, want %0d", last_of_run, want.last));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the queued transactions, each after its own idle draw.
  // The model is stepped on the edge where the transaction is accepted.
  // ---------------------------------------------------------------------------
  text_item_t  cur_item;
  bit          have_item = 1'b0;
  int unsigned gap_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(cur_item.ch, cur_item.eoi);
        have_item = 1'b0;
      end
      // a drain-marked transaction waits for every due result first
      if (!have_item && text_queue.size() != 0 &&
          !(text_queue[0].drain && tokens_due.size() != 0)) begin
        cur_item  = text_queue.pop_front();
        gap_left  = cur_item.gap;
        have_item = 1'b1;
      end
      in_valid     <= have_item && gap_left == 0;
      source_byte  <= cur_item.ch;
      end_of_input <= cur_item.eoi;
      if (have_item && gap_left != 0) gap_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transaction, then stalls a drawn number of
  // cycles. Every fourth window of 32 results goes without stalls; once, a
  // long hold lets the output queue fill and back up into in_ready.
  // ---------------------------------------------------------------------------
  int unsigned ready_wait = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        compare_token();
        results_seen++;
        if (results_seen == HOLD_AT) ready_wait = HOLD_LEN;
        else if ((results_seen / 32) % 4 == 3) ready_wait = 0;
        else ready_wait = $urandom_range(0, MAX_WAIT);
      end else if (ready_wait != 0) begin
        ready_wait--;
      end
      out_ready <= (ready_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either side
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("patch_language_tokenizer_tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_end;

    // directed: byte extremes, lone and repeated carriage return, spaced
    // digits, '~' after a number, "-->" then "=" then a lone x, a comment,
    // a string with an escape, left open at end of text
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_text("4 56 7~");
    push_byte(CH_TAB, 1'b0);
    push_text("-->=x");
    push_text(";c");
    push_byte(CH_LF, 1'b0);
    push_text("\"q\\n");
    push_end();

    // random text; the first transaction waits for the directed part to drain
    drain_next = 1'b1;
    random_end = text_queue.size() + RANDOM_ITEMS;
    while (text_queue.size() < random_end) begin
      if (text_queue.size() % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
      add_fragment();
    end
    push_end();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (text_queue.size() != 0 || have_item || tokens_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("patch_language_tokenizer_tb OK");
    end else begin
      $display("patch_language_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
